FILE: design/frustum_plane_cull_macros.svh
// Assertion macros used by the checker of the frustum culler.
`ifndef FRUSTUM_PLANE_CULL_MACROS_SVH
`define FRUSTUM_PLANE_CULL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fpc_pkg.sv
package fpc_pkg;

  localparam int PLANE_COUNT = 4;
  localparam int NORMAL_REGS = 4;
  localparam int PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  localparam int COORD_W    = 24;
  localparam int NORM_W     = 16;
  localparam int RAD_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int FRAC_SHIFT = 14;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + NORM_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int SQ_W   = 2 * NORM_W - 1;
  localparam int NN_W   = SQ_W + 1;
  localparam int RNN_W  = RAD_W + NN_W;
  localparam int TEST_W = DOT_W + FRAC_SHIFT + 1;

  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  typedef enum logic [1:0] {
    PRIM_SPHERE   = 2'd0,
    PRIM_TRIANGLE = 2'd1,
    PRIM_PLANE    = 2'd2,
    PRIM_POLY     = 2'd3
  } prim_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_ORIGIN_Z      = 3'd2,
    REG_NORMAL_TOP    = 3'd3,
    REG_NORMAL_BOTTOM = 3'd4,
    REG_NORMAL_LEFT   = 3'd5,
    REG_NORMAL_RIGHT  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ISSUE,
    ENG_DRAIN,
    ENG_FINISH
  } eng_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [NORM_W-1:0] z;
    logic [NORM_W-1:0] y;
    logic [NORM_W-1:0] x;
  } normal_t;

  typedef struct packed {
    prim_e              kind;
    logic               last;
    logic [1:0]         vmax;
    logic [RAD_W-1:0]   radius;
    point_t             pa;
    point_t             pb;
    point_t             pc;
  } cmd_t;

endpackage

FILE: design/fpc_cmd_fifo.sv
module fpc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  fpc_pkg::cmd_t data_i,
  input  logic          rd_i,
  output fpc_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import fpc_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : CMD_PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : CMD_PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = CMD_CNT_W'(cnt_q + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_d = CMD_CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/fpc_front.sv
module fpc_front (
  input  logic                        push_i,
  input  logic                        fifo_full_i,
  input  logic [1:0]                  func_i,
  input  logic [fpc_pkg::COORD_W-1:0] ax_i,
  input  logic [fpc_pkg::COORD_W-1:0] ay_i,
  input  logic [fpc_pkg::COORD_W-1:0] az_i,
  input  logic [fpc_pkg::COORD_W-1:0] bx_i,
  input  logic [fpc_pkg::COORD_W-1:0] by_coord_i,
  input  logic [fpc_pkg::COORD_W-1:0] bz_i,
  input  logic [fpc_pkg::COORD_W-1:0] cx_i,
  input  logic [fpc_pkg::COORD_W-1:0] cy_i,
  input  logic [fpc_pkg::COORD_W-1:0] cz_i,
  input  logic [fpc_pkg::RAD_W-1:0]   radius_i,
  input  logic                        last_i,
  output logic                        wr_o,
  output fpc_pkg::cmd_t               cmd_o
);
  import fpc_pkg::*;

  prim_e kind;

  assign kind = prim_e'(func_i);
  assign wr_o = push_i && !fifo_full_i;

  // Only a sphere widens its test by the radius; a triangle walks all three vertices.
  always_comb begin
    cmd_o.kind   = kind;
    cmd_o.last   = last_i;
    cmd_o.vmax   = (kind == PRIM_TRIANGLE) ? 2'd2 : 2'd0;
    cmd_o.radius = (kind == PRIM_SPHERE) ? radius_i : '0;
    cmd_o.pa     = '{z: az_i, y: ay_i, x: ax_i};
    cmd_o.pb     = '{z: bz_i, y: by_coord_i, x: bx_i};
    cmd_o.pc     = '{z: cz_i, y: cy_i, x: cx_i};
  end

endmodule

FILE: design/fpc_back.sv
module fpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpc_pkg::cmd_t        cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  input  fpc_pkg::point_t      origin_i,
  input  fpc_pkg::normal_t     normal_i [fpc_pkg::PLANE_COUNT],
  input  logic                 pop,
  output logic                 empty,
  output logic                 keep_o,
  output logic [1:0]           kind_o
);
  import fpc_pkg::*;

  eng_state_e               state_q, state_d;
  logic [PIDX_W-1:0]        plane_q, plane_d;
  logic [1:0]               vtx_q, vtx_d;
  logic [PLANE_COUNT-1:0]   flags_q, flags_d;
  logic [PLANE_COUNT-1:0]   poly_q, poly_d;
  logic [PLANE_COUNT-1:0]   poly_acc;
  logic                     start, issue;
  logic                     res_valid_q, res_valid_d, res_load;
  logic                     res_keep_q, res_keep_d;
  prim_e                    res_kind_q;

  point_t                   pt;
  normal_t                  nsel;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [2*NORM_W-1:0] sqx, sqy, sqz;

  logic                     v1_q, v2_q, v3_q;
  logic [PIDX_W-1:0]        pl1_q, pl2_q, pl3_q;
  logic [RAD_W-1:0]         rad1_q, rad2_q;
  logic signed [PROD_W-1:0] prod1_q [3];
  logic [SQ_W-1:0]          sq1_q [3];
  logic signed [DOT_W-1:0]  dot2_q, dot3_q;
  logic [NN_W-1:0]          nn2_q;
  logic [RNN_W-1:0]         rnn3_q;
  logic signed [TEST_W-1:0] tsum;
  logic                     in_front;

  always_comb begin
    case (vtx_q)
      2'd0:    pt = cmd_i.pa;
      2'd1:    pt = cmd_i.pb;
      default: pt = cmd_i.pc;
    endcase
  end

  assign nsel = normal_i[plane_q];
  assign dx   = $signed({pt.x[COORD_W-1], pt.x}) - $signed({origin_i.x[COORD_W-1], origin_i.x});
  assign dy   = $signed({pt.y[COORD_W-1], pt.y}) - $signed({origin_i.y[COORD_W-1], origin_i.y});
  assign dz   = $signed({pt.z[COORD_W-1], pt.z}) - $signed({origin_i.z[COORD_W-1], origin_i.z});
  assign px   = dx * $signed(nsel.x);
  assign py   = dy * $signed(nsel.y);
  assign pz   = dz * $signed(nsel.z);
  assign sqx  = $signed(nsel.x) * $signed(nsel.x);
  assign sqy  = $signed(nsel.y) * $signed(nsel.y);
  assign sqz  = $signed(nsel.z) * $signed(nsel.z);

  // The test is dot(P - O, N) scaled to Q.14 plus radius times the squared normal length.
  assign tsum     = $signed({dot3_q, {FRAC_SHIFT{1'b0}}}) + $signed({1'b0, rnn3_q});
  assign in_front = !tsum[TEST_W-1];
  assign poly_acc = poly_q | flags_q;

  always_comb begin
    state_d    = state_q;
    plane_d    = plane_q;
    vtx_d      = vtx_q;
    poly_d     = poly_q;
    start      = 1'b0;
    issue      = 1'b0;
    cmd_pop_o  = 1'b0;
    res_load   = 1'b0;
    res_keep_d = 1'b0;
    case (state_q)
      ENG_IDLE: begin
        if (!cmd_empty_i) begin
          start   = 1'b1;
          plane_d = '0;
          vtx_d   = '0;
          state_d = (cmd_i.kind == PRIM_PLANE) ? ENG_FINISH : ENG_ISSUE;
        end
      end
      ENG_ISSUE: begin
        issue = 1'b1;
        if (vtx_q == cmd_i.vmax) begin
          vtx_d = '0;
          if (plane_q == PIDX_W'(PLANE_COUNT - 1)) begin
            state_d = ENG_DRAIN;
          end else begin
            plane_d = PIDX_W'(plane_q + 1'b1);
          end
        end else begin
          vtx_d = 2'(vtx_q + 1'b1);
        end
      end
      ENG_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ENG_FINISH;
        end
      end
      ENG_FINISH: begin
        if (cmd_i.kind == PRIM_POLY && !cmd_i.last) begin
          poly_d    = poly_acc;
          cmd_pop_o = 1'b1;
          state_d   = ENG_IDLE;
        end else if (!res_valid_q || pop) begin
          res_load  = 1'b1;
          cmd_pop_o = 1'b1;
          state_d   = ENG_IDLE;
          case (cmd_i.kind)
            PRIM_PLANE: res_keep_d = 1'b1;
            PRIM_POLY: begin
              res_keep_d = &poly_acc;
              poly_d     = '0;
            end
            default:    res_keep_d = &flags_q;
          endcase
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_comb begin
    flags_d = start ? '0 : flags_q;
    if (v3_q && in_front) begin
      flags_d[pl3_q] = 1'b1;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      plane_q     <= '0;
      vtx_q       <= '0;
      flags_q     <= '0;
      poly_q      <= '0;
      res_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_q     <= plane_d;
      vtx_q       <= vtx_d;
      flags_q     <= flags_d;
      poly_q      <= poly_d;
      res_valid_q <= res_valid_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pl1_q      <= plane_q;
    rad1_q     <= cmd_i.radius;
    prod1_q[0] <= px;
    prod1_q[1] <= py;
    prod1_q[2] <= pz;
    sq1_q[0]   <= sqx[SQ_W-1:0];
    sq1_q[1]   <= sqy[SQ_W-1:0];
    sq1_q[2]   <= sqz[SQ_W-1:0];
    pl2_q      <= pl1_q;
    rad2_q     <= rad1_q;
    dot2_q     <= DOT_W'(prod1_q[0]) + DOT_W'(prod1_q[1]) + DOT_W'(prod1_q[2]);
    nn2_q      <= NN_W'(sq1_q[0]) + NN_W'(sq1_q[1]) + NN_W'(sq1_q[2]);
    pl3_q      <= pl2_q;
    dot3_q     <= dot2_q;
    rnn3_q     <= RNN_W'(rad2_q) * RNN_W'(nn2_q);
    if (res_load) begin
      res_keep_q <= res_keep_d;
      res_kind_q <= cmd_i.kind;
    end
  end

  assign empty  = !res_valid_q;
  assign keep_o = res_keep_q;
  assign kind_o = res_kind_q;

endmodule

FILE: design/frustum_plane_cull.sv
// Channel   Handshake            Payload
// input     push / full          func_i, ax_i .. cz_i, radius_i, last_i
// result    empty / pop          keep_o, kind_o
// config    cfg_we_i             cfg_addr_i, cfg_wdata_i
//
// An infinite plane skips the plane tests. Other items are tested against every plane
// (a triangle with each of its three vertices) by the shared dot-product pipeline
// that starts one plane test per cycle and is three registers deep.
// A two-entry command queue lets the input side accept items while the engine works.
// The asynchronous reset clears the control and config registers and polygon state.
// A waiting result stalls only the end of the next item, never the input side directly.
module frustum_plane_cull (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     func_i,
  input  logic [fpc_pkg::COORD_W-1:0]    ax_i,
  input  logic [fpc_pkg::COORD_W-1:0]    ay_i,
  input  logic [fpc_pkg::COORD_W-1:0]    az_i,
  input  logic [fpc_pkg::COORD_W-1:0]    bx_i,
  input  logic [fpc_pkg::COORD_W-1:0]    by_coord_i,
  input  logic [fpc_pkg::COORD_W-1:0]    bz_i,
  input  logic [fpc_pkg::COORD_W-1:0]    cx_i,
  input  logic [fpc_pkg::COORD_W-1:0]    cy_i,
  input  logic [fpc_pkg::COORD_W-1:0]    cz_i,
  input  logic [fpc_pkg::RAD_W-1:0]      radius_i,
  input  logic                           last_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           keep_o,
  output logic [1:0]                     kind_o,
  input  logic                           cfg_we_i,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [fpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import fpc_pkg::*;

  point_t  origin_q;
  normal_t normal_q [NORMAL_REGS];
  normal_t plane_nrm [PLANE_COUNT];

  logic    fifo_wr, fifo_rd, fifo_full, fifo_empty;
  cmd_t    cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      for (int i = 0; i < NORMAL_REGS; i++) begin
        normal_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ORIGIN_X:      origin_q.x  <= cfg_wdata_i[COORD_W-1:0];
        REG_ORIGIN_Y:      origin_q.y  <= cfg_wdata_i[COORD_W-1:0];
        REG_ORIGIN_Z:      origin_q.z  <= cfg_wdata_i[COORD_W-1:0];
        REG_NORMAL_TOP:    normal_q[0] <= cfg_wdata_i;
        REG_NORMAL_BOTTOM: normal_q[1] <= cfg_wdata_i;
        REG_NORMAL_LEFT:   normal_q[2] <= cfg_wdata_i;
        REG_NORMAL_RIGHT:  normal_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Planes without a register have a zero normal and so never reject.
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
    if (g < NORMAL_REGS) begin : g_reg
      assign plane_nrm[g] = normal_q[g];
    end else begin : g_zero
      assign plane_nrm[g] = '0;
    end
  end

  assign full = fifo_full;

  fpc_front u_front (
    .push_i      (push),
    .fifo_full_i (fifo_full),
    .func_i      (func_i),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .az_i        (az_i),
    .bx_i        (bx_i),
    .by_coord_i  (by_coord_i),
    .bz_i        (bz_i),
    .cx_i        (cx_i),
    .cy_i        (cy_i),
    .cz_i        (cz_i),
    .radius_i    (radius_i),
    .last_i      (last_i),
    .wr_o        (fifo_wr),
    .cmd_o       (cmd_in)
  );

  fpc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_wr),
    .data_i  (cmd_in),
    .rd_i    (fifo_rd),
    .data_o  (cmd_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  fpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (fifo_empty),
    .cmd_pop_o   (fifo_rd),
    .origin_i    (origin_q),
    .normal_i    (plane_nrm),
    .pop         (pop),
    .empty       (empty),
    .keep_o      (keep_o),
    .kind_o      (kind_o)
  );

endmodule

FILE: design/fpc_checker.sv
`include "frustum_plane_cull_macros.svh"

module fpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       keep_o,
  input logic [1:0] kind_o
);
  import fpc_pkg::*;

  `FPC_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(keep_o) && $stable(kind_o), "result changed while stalled")
  `FPC_ASSERT_NOW(a_plane_kept, !empty && kind_o == PRIM_PLANE, keep_o, "infinite plane was culled")
  `FPC_ASSERT_NOW(a_full_after_push, $rose(full), $past(push && !full), "queue filled without an item")
  `FPC_ASSERT_NOW(a_empty_after_pop, $rose(empty), $past(pop), "result vanished without a pop")

endmodule

bind frustum_plane_cull fpc_checker u_fpc_checker (.*);
